@@ rtl/cmsp_pkg.sv @@
// Shared types, codes and keyword constants for the CMap stream parser.
package cmsp_pkg;

  // token kind codes
  localparam logic [1:0] KindIdle = 2'd0;
  localparam logic [1:0] KindHex  = 2'd1;
  localparam logic [1:0] KindWord = 2'd2;

  // section mode codes
  localparam logic [1:0] ModeNone  = 2'd0;
  localparam logic [1:0] ModeCsr   = 2'd1;
  localparam logic [1:0] ModeChar  = 2'd2;
  localparam logic [1:0] ModeRange = 2'd3;

  // keyword flag bits
  localparam int FlagCsr   = 0;
  localparam int FlagChar  = 1;
  localparam int FlagRange = 2;
  localparam int FlagEnd   = 3;

  localparam logic [4:0] FlagsAll = 5'h1F;
  localparam logic [4:0] LenMax   = 5'd31;

  // delimiter characters
  localparam logic [7:0] CharLt  = 8'h3C;  // <
  localparam logic [7:0] CharGt  = 8'h3E;  // >
  localparam logic [7:0] CharLBr = 8'h5B;  // [
  localparam logic [7:0] CharRBr = 8'h5D;  // ]

  // keywords, first character in the most significant byte
  localparam int          WordBits = 8 * 19;
  localparam logic [4:0]  LenCsr   = 5'd19;
  localparam logic [4:0]  LenChar  = 5'd11;
  localparam logic [4:0]  LenRange = 5'd12;
  localparam logic [4:0]  LenEnd   = 5'd3;
  localparam logic [8*19-1:0] WordCsr   = "begincodespacerange";
  localparam logic [8*11-1:0] WordChar  = "beginbfchar";
  localparam logic [8*12-1:0] WordRange = "beginbfrange";
  localparam logic [8*3-1:0]  WordEnd   = "end";

  // unicode surrogate constants
  localparam logic [15:0] HiSurLo = 16'hD800;
  localparam logic [15:0] HiSurHi = 16'hDBFF;
  localparam logic [15:0] LoSurLo = 16'hDC00;
  localparam logic [15:0] LoSurHi = 16'hDFFF;
  localparam logic [20:0] SupBase = 21'h10000;

  typedef struct packed {
    logic        has_result;
    logic        entry_valid;
    logic [15:0] code_low;
    logic [15:0] code_high;
    logic [20:0] uni_first;
    logic [15:0] uni_second;
    logic [6:0]  code_width_bytes;
    logic        stream_done;
  } cmsp_result_t;

  // character p of an n-character word held right-aligned in w
  function automatic logic [7:0] word_char(logic [WordBits-1:0] w, logic [4:0] n,
                                           logic [4:0] p);
    logic [4:0] idx;
    idx = (p < n) ? (n - 5'd1 - p) : 5'd0;
    return w[{idx, 3'b000} +: 8];
  endfunction

endpackage

@@ rtl/cmsp_word_match.sv @@
// Keyword matcher: appends one character to the running keyword match.
module cmsp_word_match import cmsp_pkg::*; (
  input  logic [4:0] len_i,
  input  logic [4:0] flags_i,
  input  logic [7:0] char_i,
  output logic [4:0] len_o,
  output logic [4:0] flags_o
);

  logic hit_csr, hit_chr, hit_rng, miss_end;

  assign hit_csr  = (len_i < LenCsr) &&
                    (char_i == word_char(WordBits'(WordCsr), LenCsr, len_i));
  assign hit_chr  = (len_i < LenChar) &&
                    (char_i == word_char(WordBits'(WordChar), LenChar, len_i));
  assign hit_rng  = (len_i < LenRange) &&
                    (char_i == word_char(WordBits'(WordRange), LenRange, len_i));
  assign miss_end = (len_i < LenEnd) &&
                    (char_i != word_char(WordBits'(WordEnd), LenEnd, len_i));

  always_comb begin
    flags_o            = flags_i;
    flags_o[FlagCsr]   = flags_i[FlagCsr] & hit_csr;
    flags_o[FlagChar]  = flags_i[FlagChar] & hit_chr;
    flags_o[FlagRange] = flags_i[FlagRange] & hit_rng;
    flags_o[FlagEnd]   = flags_i[FlagEnd] & ~miss_end;
  end

  assign len_o = (len_i < LenMax) ? len_i + 5'd1 : len_i;

endmodule

@@ rtl/cmsp_parser.sv @@
// Parser state and per-byte next-state logic; produces at most one result per beat.
module cmsp_parser import cmsp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output cmsp_result_t res_o
);

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] phase;
    logic       arr;
  } sect_t;

  logic [1:0]  kind_q, kind_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  nib_q, nib_d;
  logic [15:0] unit0_q, unit0_d, unit1_q, unit1_d;
  logic [1:0]  ucnt_q, ucnt_d;
  logic [7:0]  dcnt_q, dcnt_d;
  logic [4:0]  kwlen_q, kwlen_d;
  logic [4:0]  kwflags_q, kwflags_d;
  logic [1:0]  mode_q, mode_d;
  logic [1:0]  phase_q, phase_d;
  logic        arr_q, arr_d;
  logic [15:0] rlo_q, rlo_d, rhi_q, rhi_d;
  logic [15:0] pend_q, pend_d;
  logic [6:0]  width_q, width_d;

  logic       is_space, is_punct, hex_ok;
  logic [3:0] hex_val;
  logic       digit_step, append_step, word_fin1, start_tok, hex_fin1;
  logic       start_word;
  logic [1:0] kind_mid;
  logic       word_fin2, hex_fin;
  logic [4:0] wm_len_in, wm_flags_in, wm_len, wm_flags;

  function automatic sect_t finish_word(logic [4:0] f, logic [4:0] len, sect_t s);
    sect_t r;
    r = s;
    if (f[FlagCsr] && len == LenCsr) begin
      r.mode = ModeCsr;  r.phase = 2'd0;
    end else if (f[FlagChar] && len == LenChar) begin
      r.mode = ModeChar; r.phase = 2'd0;
    end else if (f[FlagRange] && len == LenRange) begin
      r.mode = ModeRange; r.phase = 2'd0;
    end else if (f[FlagEnd] && len >= LenEnd) begin
      r.mode = ModeNone; r.phase = 2'd0; r.arr = 1'b0;
    end
    return r;
  endfunction

  // byte classes
  always_comb begin
    is_space = (byte_i == 8'd32) || (byte_i == 8'd9) || (byte_i == 8'd13) ||
               (byte_i == 8'd10) || (byte_i == 8'd12) || (byte_i == 8'd0);
    is_punct = (byte_i == CharLt) || (byte_i == CharLBr) || (byte_i == CharRBr);
    hex_ok   = 1'b1;
    hex_val  = 4'd0;
    if (byte_i >= "0" && byte_i <= "9")      hex_val = 4'(byte_i - "0");
    else if (byte_i >= "a" && byte_i <= "f") hex_val = 4'(byte_i - "a" + 8'd10);
    else if (byte_i >= "A" && byte_i <= "F") hex_val = 4'(byte_i - "A" + 8'd10);
    else hex_ok = 1'b0;
  end

  // what this byte does to the token in flight
  always_comb begin
    hex_fin1    = (kind_q == KindHex) && (byte_i == CharGt);
    digit_step  = (kind_q == KindHex) && (byte_i != CharGt) && hex_ok;
    word_fin1   = (kind_q == KindWord) && (is_space || is_punct);
    append_step = (kind_q == KindWord) && !is_space && !is_punct;
    start_tok   = ((kind_q == KindWord) && is_punct) || ((kind_q == KindIdle) && !is_space);
    start_word  = start_tok && !is_punct;
    kind_mid    = kind_q;
    if (hex_fin1 || word_fin1) kind_mid = KindIdle;
    if (start_tok) begin
      if (byte_i == CharLt)  kind_mid = KindHex;
      else if (!is_punct)    kind_mid = KindWord;
    end
    word_fin2   = last_i && (kind_mid == KindWord);
    hex_fin     = hex_fin1 || (last_i && (kind_mid == KindHex));
    wm_len_in   = start_word ? 5'd0 : kwlen_q;
    wm_flags_in = start_word ? FlagsAll : kwflags_q;
  end

  cmsp_word_match u_word_match (
    .len_i   (wm_len_in),
    .flags_i (wm_flags_in),
    .char_i  (byte_i),
    .len_o   (wm_len),
    .flags_o (wm_flags)
  );

  always_comb begin
    sect_t       s;
    logic [15:0] v0;
    logic [20:0] u0;
    logic [15:0] u1;
    logic [15:0] e_lo, e_hi;
    logic        got;

    kind_d = kind_q;   acc_d = acc_q;     nib_d = nib_q;
    unit0_d = unit0_q; unit1_d = unit1_q; ucnt_d = ucnt_q;
    dcnt_d = dcnt_q;   kwlen_d = kwlen_q; kwflags_d = kwflags_q;
    mode_d = mode_q;   phase_d = phase_q; arr_d = arr_q;
    rlo_d = rlo_q;     rhi_d = rhi_q;     pend_d = pend_q;
    width_d = width_q;
    got = 1'b0; e_lo = 16'd0; e_hi = 16'd0; u0 = 21'd0; u1 = 16'd0; v0 = 16'd0;
    s = '0;

    // hex digit into the accumulator, 16-bit units pushed every 4 digits
    if (digit_step) begin
      acc_d = {acc_q[11:0], hex_val};
      if (dcnt_q != 8'd255) dcnt_d = dcnt_q + 8'd1;
      if (nib_q == 2'd3) begin
        if (ucnt_q == 2'd0)      unit0_d = acc_d;
        else if (ucnt_q == 2'd1) unit1_d = acc_d;
        if (ucnt_q != 2'd3) ucnt_d = ucnt_q + 2'd1;
        acc_d = 16'd0;
        nib_d = 2'd0;
      end else begin
        nib_d = nib_q + 2'd1;
      end
    end

    if (append_step) begin
      kwlen_d = wm_len; kwflags_d = wm_flags;
    end

    // keyword ended by whitespace or a delimiter
    if (word_fin1) begin
      s = finish_word(kwflags_q, kwlen_q, {mode_d, phase_d, arr_d});
      mode_d = s.mode; phase_d = s.phase; arr_d = s.arr;
      kind_d = KindIdle;
    end

    if (start_tok) begin
      if (byte_i == CharLt) begin
        kind_d = KindHex;
        acc_d = 16'd0; nib_d = 2'd0; unit0_d = 16'd0; unit1_d = 16'd0;
        ucnt_d = 2'd0; dcnt_d = 8'd0;
      end else if (byte_i == CharLBr) begin
        arr_d = 1'b1;
      end else if (byte_i == CharRBr) begin
        arr_d = 1'b0; phase_d = 2'd0;
      end else begin
        kind_d = KindWord;
        kwlen_d = wm_len; kwflags_d = wm_flags;
      end
    end

    // keyword still open at the final byte
    if (word_fin2) begin
      s = finish_word(kwflags_d, kwlen_d, {mode_d, phase_d, arr_d});
      mode_d = s.mode; phase_d = s.phase; arr_d = s.arr;
      kind_d = KindIdle;
    end

    if (hex_fin) begin
      if (nib_d != 2'd0) begin
        if (ucnt_d == 2'd0)      unit0_d = acc_d;
        else if (ucnt_d == 2'd1) unit1_d = acc_d;
        if (ucnt_d != 2'd3) ucnt_d = ucnt_d + 2'd1;
      end
      kind_d = KindIdle;
      v0 = (ucnt_d != 2'd0) ? unit0_d : 16'd0;
      unique case (mode_d)
        ModeCsr: begin
          if (phase_d == 2'd0) begin
            width_d = (dcnt_d[7:1] == 7'd0) ? 7'd1 : dcnt_d[7:1];
          end
          phase_d = phase_d ^ 2'd1;
        end
        ModeChar: begin
          if (phase_d == 2'd0) begin
            pend_d = v0; phase_d = 2'd1;
          end else begin
            got = 1'b1; e_lo = pend_d; e_hi = pend_d; phase_d = 2'd0;
          end
        end
        ModeRange: begin
          if (arr_d) begin
            got = 1'b1; e_lo = rlo_d; e_hi = rlo_d;
            if (rlo_d != 16'hFFFF) rlo_d = rlo_d + 16'd1;
          end else if (phase_d == 2'd0) begin
            rlo_d = v0; phase_d = 2'd1;
          end else if (phase_d == 2'd1) begin
            rhi_d = v0; phase_d = 2'd2;
          end else begin
            got = 1'b1; e_lo = rlo_d; e_hi = rhi_d; phase_d = 2'd0;
          end
        end
        default: ;
      endcase
      // destination value, surrogate pair combined or ligature unit kept
      u0 = {5'd0, v0};
      if (ucnt_d >= 2'd2) begin
        if (unit0_d >= HiSurLo && unit0_d <= HiSurHi &&
            unit1_d >= LoSurLo && unit1_d <= LoSurHi) begin
          u0 = SupBase + {1'b0, unit0_d[9:0], 10'd0} + {11'd0, unit1_d[9:0]};
        end else begin
          u1 = unit1_d;
        end
      end
    end

    res_o.has_result       = got || last_i;
    res_o.entry_valid      = got;
    res_o.code_low         = got ? e_lo : 16'd0;
    res_o.code_high        = got ? e_hi : 16'd0;
    res_o.uni_first        = got ? u0 : 21'd0;
    res_o.uni_second       = got ? u1 : 16'd0;
    res_o.code_width_bytes = width_d;
    res_o.stream_done      = last_i;

    // end of stream: everything back to its reset value
    if (last_i) begin
      kind_d = KindIdle; acc_d = 16'd0; nib_d = 2'd0;
      unit0_d = 16'd0; unit1_d = 16'd0; ucnt_d = 2'd0; dcnt_d = 8'd0;
      kwlen_d = 5'd0; kwflags_d = FlagsAll;
      mode_d = ModeNone; phase_d = 2'd0; arr_d = 1'b0;
      rlo_d = 16'd0; rhi_d = 16'd0; pend_d = 16'd0; width_d = 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindIdle; acc_q <= 16'd0; nib_q <= 2'd0;
      unit0_q <= 16'd0; unit1_q <= 16'd0; ucnt_q <= 2'd0; dcnt_q <= 8'd0;
      kwlen_q <= 5'd0; kwflags_q <= FlagsAll;
      mode_q <= ModeNone; phase_q <= 2'd0; arr_q <= 1'b0;
      rlo_q <= 16'd0; rhi_q <= 16'd0; pend_q <= 16'd0; width_q <= 7'd1;
    end else if (step_i) begin
      kind_q <= kind_d; acc_q <= acc_d; nib_q <= nib_d;
      unit0_q <= unit0_d; unit1_q <= unit1_d; ucnt_q <= ucnt_d; dcnt_q <= dcnt_d;
      kwlen_q <= kwlen_d; kwflags_q <= kwflags_d;
      mode_q <= mode_d; phase_q <= phase_d; arr_q <= arr_d;
      rlo_q <= rlo_d; rhi_q <= rhi_d; pend_q <= pend_d; width_q <= width_d;
    end
  end

endmodule

@@ rtl/cmap_stream_parser_core.sv @@
// Top level of the ToUnicode CMap stream parser: input register, parser, result register.
// Flow: a beat is held in the input register and parsed from there; its result (if any)
//   is written to the output register. Throughput: one byte per cycle, except that a byte
//   with a result waits on a full, unread output; bytes with none never wait for it.
// Reset: rst_ni is asynchronous and active low; it empties both registers and puts the
//   parser in its idle state with code width 1. The final byte of a stream also resets the parser so.
module cmap_stream_parser_core import cmsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        stream_last_i,
  // mapping entries out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        entry_valid_o,
  output logic [15:0] code_low_o,
  output logic [15:0] code_high_o,
  output logic [20:0] uni_first_o,
  output logic [15:0] uni_second_o,
  output logic [6:0]  code_width_bytes_o,
  output logic        stream_done_o
);

  logic         in_valid_q;
  logic [7:0]   byte_q;
  logic         last_q;
  logic         fire;
  cmsp_result_t res;
  cmsp_result_t out_q;
  logic         out_valid_q;

  // a beat moves on when it has no result or the result register is free
  assign fire       = in_valid_q && (!res.has_result || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= stream_byte_i;
      last_q <= stream_last_i;
    end
  end

  cmsp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .byte_i (byte_q),
    .last_i (last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res.has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.has_result) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign entry_valid_o      = out_q.entry_valid;
  assign code_low_o         = out_q.code_low;
  assign code_high_o        = out_q.code_high;
  assign uni_first_o        = out_q.uni_first;
  assign uni_second_o       = out_q.uni_second;
  assign code_width_bytes_o = out_q.code_width_bytes;
  assign stream_done_o      = out_q.stream_done;

endmodule
